>>> rtl/lsfe_pkg.sv
// Shared types and constants of the LED strip frame encoder.
`default_nettype none
package lsfe_pkg;

  // Field widths of the channels
  localparam int OPCODE_W   = 2;
  localparam int LINE_W     = 3;
  localparam int POS_W      = 11;
  localparam int BYTE_W     = 8;
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int MODE_W     = 3;
  localparam int PIXCNT_W   = 12;

  // Read pointers keep 11 bits per line
  localparam int PTR_W = 11;
  // Byte index of a set-pixel write: position*3 + 2 fits in 13 bits
  localparam int IDX_W = 13;
  // Monochrome target: position + 2
  localparam int TGT_W = 12;
  localparam int BITS_PER_BYTE = 8;

  // Luma = (2126 r + 7152 g + 722 b) / 10000
  localparam int unsigned LUMA_R_COEF = 2126;
  localparam int unsigned LUMA_G_COEF = 7152;
  localparam int unsigned LUMA_B_COEF = 722;
  localparam int LUMA_SUM_W  = 22;
  // ceil(2^36 / 10000); exact for every sum below 2^22
  localparam int LUMA_RECIP_W = 23;
  localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 23'd6871948;
  localparam int LUMA_SHIFT  = 36;
  localparam int LUMA_PROD_W = LUMA_SUM_W + LUMA_RECIP_W;

  // position / 12 as (position * 2731) >> 15, exact below 2^11
  localparam int MOD_DIV     = 12;
  localparam int MOD_RECIP_W = 12;
  localparam logic [MOD_RECIP_W-1:0] MOD_RECIP = 12'd2731;
  localparam int MOD_SHIFT   = 15;
  localparam int MOD_PROD_W  = POS_W + MOD_RECIP_W;
  localparam int MOD_Q_W     = 8;
  localparam int MOD_R_W     = 4;

  // Opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_SET_BYTE  = 2'd1,
    OP_EMIT      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  // Color modes
  localparam logic [MODE_W-1:0] MODE_RGB  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RBG  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GRB  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GBR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BRG  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BGR  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_MONO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_OFF  = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW    = 3'd5;

  // Register reset values
  localparam logic [MODE_W-1:0] RST_COLOR_MODE = MODE_GRB;
  localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 8'd60;
  localparam logic [TICK_W-1:0] RST_ONE_LOW    = 8'd40;
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 8'd30;
  localparam logic [TICK_W-1:0] RST_ZERO_LOW   = 8'd70;

  // Latched input item
  typedef struct packed {
    op_t               opcode;
    logic [LINE_W-1:0] line;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] byte_value;
  } item_t;

  // Frame store access requested by the controller
  typedef enum logic [2:0] {
    RAM_NONE,
    RAM_CLEAR,
    RAM_PIX0,
    RAM_PIX1,
    RAM_PIX2,
    RAM_MONO,
    RAM_RAW,
    RAM_READ
  } ram_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    take_item;
    ram_op_t ram_op;
    logic    luma_ld;
    logic    mono_ld;
    logic    byte_ld;
    logic    out_bit_ld;
    logic    out_end_ld;
    logic    bit_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic line_ok;
    op_t  opcode;
    logic mono_mode;
    logic mode_off;
    logic len_zero;
    logic slot_free;
    logic clear_done;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/lsfe_if.sv
// Handshake channels of the LED strip frame encoder: input, result and configuration.
`default_nettype none
interface lsfe_in_if;
  logic                          valid;
  logic                          ready;
  logic [lsfe_pkg::OPCODE_W-1:0] opcode;
  logic [lsfe_pkg::LINE_W-1:0]   line;
  logic [lsfe_pkg::POS_W-1:0]    position;
  logic [lsfe_pkg::BYTE_W-1:0]   red;
  logic [lsfe_pkg::BYTE_W-1:0]   green;
  logic [lsfe_pkg::BYTE_W-1:0]   blue;
  logic [lsfe_pkg::BYTE_W-1:0]   byte_value;

  modport source (output valid, opcode, line, position, red, green, blue, byte_value,
                  input ready);
  modport sink   (input valid, opcode, line, position, red, green, blue, byte_value,
                  output ready);
endinterface

interface lsfe_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsfe_pkg::TICK_W-1:0] high_ticks;
  logic [lsfe_pkg::TICK_W-1:0] low_ticks;
  logic                        frame_end;

  modport source (output valid, high_ticks, low_ticks, frame_end, input ready);
  modport sink   (input valid, high_ticks, low_ticks, frame_end, output ready);
endinterface

interface lsfe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lsfe_pkg::CFG_IDX_W-1:0]  index;
  logic [lsfe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/lsfe_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lsfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/lsfe_ctrl.sv
// Controller: sequences store clearing, writes, byte reads and pulse output.
`default_nettype none
module lsfe_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lsfe_pkg::dp_status_t status,
  output lsfe_pkg::dp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_PIX1,
    S_PIX2,
    S_MOD,
    S_MONO,
    S_RDWAIT,
    S_EMIT,
    S_END
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic       bit_last;

  assign in_ready = (state_r == S_IDLE);
  assign bit_last = (bit_cnt_r == 3'(lsfe_pkg::BITS_PER_BYTE - 1));

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    cmd           = '0;
    cmd.ram_op    = lsfe_pkg::RAM_NONE;
    cmd.bit_last  = bit_last;
    case (state_r)
      S_CLEAR: begin
        cmd.ram_op = lsfe_pkg::RAM_CLEAR;
        if (status.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        if (status.line_ok) begin
          case (status.opcode)
            lsfe_pkg::OP_SET_PIXEL: begin
              if (status.mono_mode) begin
                cmd.luma_ld = 1'b1;
                state_nxt   = S_MOD;
              end else if (!status.mode_off) begin
                cmd.ram_op = lsfe_pkg::RAM_PIX0;
                state_nxt  = S_PIX1;
              end
            end
            lsfe_pkg::OP_SET_BYTE: begin
              cmd.ram_op = lsfe_pkg::RAM_RAW;
            end
            lsfe_pkg::OP_EMIT: begin
              if (status.len_zero) begin
                state_nxt = S_END;
              end else begin
                cmd.ram_op = lsfe_pkg::RAM_READ;
                state_nxt  = S_RDWAIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_PIX1: begin
        cmd.ram_op = lsfe_pkg::RAM_PIX1;
        state_nxt  = S_PIX2;
      end
      S_PIX2: begin
        cmd.ram_op = lsfe_pkg::RAM_PIX2;
        state_nxt  = S_IDLE;
      end
      S_MOD: begin
        cmd.mono_ld = 1'b1;
        state_nxt   = S_MONO;
      end
      S_MONO: begin
        cmd.ram_op = lsfe_pkg::RAM_MONO;
        state_nxt  = S_IDLE;
      end
      S_RDWAIT: begin
        cmd.byte_ld = 1'b1;
        bit_cnt_nxt = '0;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.out_bit_ld = 1'b1;
          bit_cnt_nxt    = bit_cnt_r + 3'd1;
          if (bit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_END: begin
        if (status.slot_free) begin
          cmd.out_end_ld = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lsfe_dp.sv
// Datapath: registers, read pointers, luma and placement math, store access, result register.
`default_nettype none
module lsfe_dp #(
  parameter int LINES      = 8,
  parameter int LINE_BYTES = 2048
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  lsfe_in_if.sink                                         in_ch,
  lsfe_out_if.source                                      out_ch,
  lsfe_cfg_if.sink                                        cfg_ch,
  input  wire lsfe_pkg::dp_cmd_t                          cmd,
  output lsfe_pkg::dp_status_t                            status,
  output logic                                            ram_we,
  output logic                                            ram_re,
  output logic [$clog2(LINES*LINE_BYTES)-1:0]             ram_addr,
  output logic [lsfe_pkg::BYTE_W-1:0]                     ram_wdata,
  input  wire logic [lsfe_pkg::BYTE_W-1:0]                ram_rdata
);

  localparam int DEPTH  = LINES * LINE_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(LINE_BYTES + 1);
  localparam int LIDX_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int N_W    = lsfe_pkg::PIXCNT_W + 2;

  // Configuration registers
  logic [lsfe_pkg::MODE_W-1:0]   color_mode_r;
  logic [lsfe_pkg::PIXCNT_W-1:0] pixel_count_r;
  logic [lsfe_pkg::TICK_W-1:0]   one_high_r, one_low_r, zero_high_r, zero_low_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r  <= lsfe_pkg::RST_COLOR_MODE;
      pixel_count_r <= '0;
      one_high_r    <= lsfe_pkg::RST_ONE_HIGH;
      one_low_r     <= lsfe_pkg::RST_ONE_LOW;
      zero_high_r   <= lsfe_pkg::RST_ZERO_HIGH;
      zero_low_r    <= lsfe_pkg::RST_ZERO_LOW;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        lsfe_pkg::REG_COLOR_MODE:  color_mode_r  <= cfg_ch.data[lsfe_pkg::MODE_W-1:0];
        lsfe_pkg::REG_PIXEL_COUNT: pixel_count_r <= cfg_ch.data[lsfe_pkg::PIXCNT_W-1:0];
        lsfe_pkg::REG_ONE_HIGH:    one_high_r    <= cfg_ch.data[lsfe_pkg::TICK_W-1:0];
        lsfe_pkg::REG_ONE_LOW:     one_low_r     <= cfg_ch.data[lsfe_pkg::TICK_W-1:0];
        lsfe_pkg::REG_ZERO_HIGH:   zero_high_r   <= cfg_ch.data[lsfe_pkg::TICK_W-1:0];
        lsfe_pkg::REG_ZERO_LOW:    zero_low_r    <= cfg_ch.data[lsfe_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame length: pixels times bytes per pixel, clamped to the line
  logic           mono_mode;
  logic [N_W-1:0] len_raw;
  logic [LEN_W-1:0] len;

  assign mono_mode = (color_mode_r == lsfe_pkg::MODE_MONO);
  assign len_raw   = mono_mode ? N_W'(pixel_count_r)
                               : N_W'(pixel_count_r) + {1'b0, pixel_count_r, 1'b0};
  assign len       = (32'(len_raw) > LINE_BYTES) ? LEN_W'(LINE_BYTES) : LEN_W'(len_raw);

  // Item latch
  lsfe_pkg::item_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_r.opcode     <= lsfe_pkg::op_t'(in_ch.opcode);
      item_r.line       <= in_ch.line;
      item_r.position   <= in_ch.position;
      item_r.red        <= in_ch.red;
      item_r.green      <= in_ch.green;
      item_r.blue       <= in_ch.blue;
      item_r.byte_value <= in_ch.byte_value;
    end
  end

  logic line_ok;
  assign line_ok = (32'(item_r.line) < LINES);

  // Read pointers, one per line
  logic [lsfe_pkg::PTR_W-1:0] ptr_r [LINES];
  logic [lsfe_pkg::PTR_W-1:0] ptr_cur, p_eff, p_r, p_next;
  logic [LIDX_W-1:0]          lidx;
  logic                       last_byte;

  assign lidx      = item_r.line[LIDX_W-1:0];
  assign ptr_cur   = line_ok ? ptr_r[lidx] : '0;
  // A pointer left past a shortened frame restarts at the first byte
  assign p_eff     = (32'(ptr_cur) >= 32'(len)) ? '0 : ptr_cur;
  assign last_byte = ((32'(p_r) + 32'd1) == 32'(len));
  assign p_next    = last_byte ? '0 : p_r + lsfe_pkg::PTR_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.ram_op == lsfe_pkg::RAM_READ) begin
      p_r <= p_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) begin
        ptr_r[i] <= '0;
      end
    end else if (cmd.out_bit_ld && cmd.bit_last) begin
      ptr_r[lidx] <= p_next;
    end else if (cmd.out_end_ld) begin
      ptr_r[lidx] <= '0;
    end
  end

  // Luma sum and position / 12, first step
  logic [lsfe_pkg::LUMA_SUM_W-1:0] luma_sum_r;
  logic [lsfe_pkg::MOD_PROD_W-1:0] mod_prod;
  logic [lsfe_pkg::MOD_Q_W-1:0]    mod_q_r;

  assign mod_prod = lsfe_pkg::MOD_PROD_W'(item_r.position)
                  * lsfe_pkg::MOD_PROD_W'(lsfe_pkg::MOD_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.luma_ld) begin
      luma_sum_r <= lsfe_pkg::LUMA_SUM_W'(lsfe_pkg::LUMA_R_COEF * 32'(item_r.red)
                                        + lsfe_pkg::LUMA_G_COEF * 32'(item_r.green)
                                        + lsfe_pkg::LUMA_B_COEF * 32'(item_r.blue));
      mod_q_r    <= mod_prod[lsfe_pkg::MOD_SHIFT +: lsfe_pkg::MOD_Q_W];
    end
  end

  // Luma quotient and monochrome placement, second step
  logic [lsfe_pkg::LUMA_PROD_W-1:0] luma_prod;
  logic [lsfe_pkg::MOD_R_W-1:0]     mod_r;
  logic [lsfe_pkg::TGT_W-1:0]       tgt;
  logic [lsfe_pkg::TGT_W-1:0]       tgt_r;
  logic [lsfe_pkg::BYTE_W-1:0]      luma_r;
  logic                             mono_ok_r;

  assign luma_prod = lsfe_pkg::LUMA_PROD_W'(luma_sum_r)
                   * lsfe_pkg::LUMA_PROD_W'(lsfe_pkg::LUMA_RECIP);
  assign mod_r     = lsfe_pkg::MOD_R_W'(item_r.position
                   - lsfe_pkg::POS_W'(mod_q_r) * lsfe_pkg::POS_W'(lsfe_pkg::MOD_DIV));

  // Within each group of twelve, bytes six and nine move up two, eight and eleven down two
  always_comb begin
    tgt = lsfe_pkg::TGT_W'(item_r.position);
    if (mod_r inside {4'd6, 4'd9}) begin
      tgt = lsfe_pkg::TGT_W'(item_r.position) + lsfe_pkg::TGT_W'(2);
    end else if (mod_r inside {4'd8, 4'd11}) begin
      tgt = lsfe_pkg::TGT_W'(item_r.position) - lsfe_pkg::TGT_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mono_ld) begin
      luma_r    <= luma_prod[lsfe_pkg::LUMA_SHIFT +: lsfe_pkg::BYTE_W];
      tgt_r     <= tgt;
      mono_ok_r <= (32'(item_r.position) < 32'(len)) && (32'(tgt) < 32'(len));
    end
  end

  // Color order of a set pixel
  logic [lsfe_pkg::BYTE_W-1:0] x0, x1, x2;

  always_comb begin
    case (color_mode_r)
      lsfe_pkg::MODE_RGB: begin x0 = item_r.red;   x1 = item_r.green; x2 = item_r.blue;  end
      lsfe_pkg::MODE_RBG: begin x0 = item_r.red;   x1 = item_r.blue;  x2 = item_r.green; end
      lsfe_pkg::MODE_GRB: begin x0 = item_r.green; x1 = item_r.red;   x2 = item_r.blue;  end
      lsfe_pkg::MODE_GBR: begin x0 = item_r.green; x1 = item_r.blue;  x2 = item_r.red;   end
      lsfe_pkg::MODE_BRG: begin x0 = item_r.blue;  x1 = item_r.red;   x2 = item_r.green; end
      default:            begin x0 = item_r.blue;  x1 = item_r.green; x2 = item_r.red;   end
    endcase
  end

  // Clearing sweep counter
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.ram_op == lsfe_pkg::RAM_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // Frame store access
  logic [lsfe_pkg::IDX_W-1:0] base, idx;
  logic                       pix_ok;
  logic [31:0]                line_base;

  assign base      = lsfe_pkg::IDX_W'(item_r.position)
                   + {1'b0, item_r.position, 1'b0};
  assign pix_ok    = (32'(base) < 32'(len));
  assign line_base = 32'(item_r.line) * LINE_BYTES;

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = '0;
    idx       = base;
    case (cmd.ram_op)
      lsfe_pkg::RAM_CLEAR: begin
        ram_we = 1'b1;
      end
      lsfe_pkg::RAM_PIX0: begin
        idx       = base;
        ram_we    = pix_ok && (32'(idx) < LINE_BYTES);
        ram_wdata = x0;
      end
      lsfe_pkg::RAM_PIX1: begin
        idx       = base + lsfe_pkg::IDX_W'(1);
        ram_we    = pix_ok && (32'(idx) < LINE_BYTES);
        ram_wdata = x1;
      end
      lsfe_pkg::RAM_PIX2: begin
        idx       = base + lsfe_pkg::IDX_W'(2);
        ram_we    = pix_ok && (32'(idx) < LINE_BYTES);
        ram_wdata = x2;
      end
      lsfe_pkg::RAM_MONO: begin
        idx       = lsfe_pkg::IDX_W'(tgt_r);
        ram_we    = mono_ok_r;
        ram_wdata = luma_r;
      end
      lsfe_pkg::RAM_RAW: begin
        idx       = lsfe_pkg::IDX_W'(item_r.position);
        ram_we    = (32'(item_r.position) < 32'(len));
        ram_wdata = item_r.byte_value;
      end
      lsfe_pkg::RAM_READ: begin
        idx    = lsfe_pkg::IDX_W'(p_eff);
        ram_re = 1'b1;
      end
      default: ;
    endcase
    ram_addr = (cmd.ram_op == lsfe_pkg::RAM_CLEAR) ? clr_cnt_r
                                                  : ADDR_W'(line_base + 32'(idx));
  end

  // Byte being sent, MSB first
  logic [lsfe_pkg::BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (cmd.byte_ld) begin
      byte_r <= ram_rdata;
    end else if (cmd.out_bit_ld) begin
      byte_r <= {byte_r[lsfe_pkg::BYTE_W-2:0], 1'b0};
    end
  end

  // Result register
  logic                        out_valid_r;
  logic [lsfe_pkg::TICK_W-1:0] high_r, low_r;
  logic                        fe_r;
  logic                        slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_bit_ld || cmd.out_end_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_bit_ld) begin
      high_r <= byte_r[lsfe_pkg::BYTE_W-1] ? one_high_r : zero_high_r;
      low_r  <= byte_r[lsfe_pkg::BYTE_W-1] ? one_low_r  : zero_low_r;
      fe_r   <= cmd.bit_last && last_byte;
    end else if (cmd.out_end_ld) begin
      high_r <= '0;
      low_r  <= '0;
      fe_r   <= 1'b1;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.high_ticks = high_r;
  assign out_ch.low_ticks  = low_r;
  assign out_ch.frame_end  = fe_r;

  // Status to the controller
  always_comb begin
    status            = '0;
    status.line_ok    = line_ok;
    status.opcode     = item_r.opcode;
    status.mono_mode  = mono_mode;
    status.mode_off   = (color_mode_r == lsfe_pkg::MODE_OFF);
    status.len_zero   = (len == '0);
    status.slot_free  = slot_free;
    status.clear_done = (32'(clr_cnt_r) == DEPTH - 1);
  end

endmodule
`default_nettype wire

>>> rtl/led_strip_frame_encoder_top.sv
// Top level of the LED strip frame encoder.
`default_nettype none
// Frame store of LINES lines of LINE_BYTES bytes and a pulse encoder for smart-LED strips.
// After reset the store is cleared one byte a cycle, during which no input item is taken;
// configuration writes are taken at any time. All work goes through one frame store port
// and one result register. A set-pixel item makes three byte writes, or the luma sum,
// reciprocal multiply and write in monochrome, and no write in the off mode; an emit item
// goes through dispatch, one registered store read, then eight pulse results, one a cycle
// while the result side is ready, set by the bit sequencer.
// An empty frame gives one zero-length end result. The last result of an item may still wait
// in the output register while the next item is taken.
module led_strip_frame_encoder_top #(
  parameter int LINES      = 8,
  parameter int LINE_BYTES = 2048
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lsfe_in_if.sink    in_ch,
  lsfe_out_if.source out_ch,
  lsfe_cfg_if.sink   cfg_ch
);

  localparam int DEPTH  = LINES * LINE_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  lsfe_pkg::dp_cmd_t          cmd;
  lsfe_pkg::dp_status_t       status;
  logic                       in_ready;
  logic                       ram_we, ram_re;
  logic [ADDR_W-1:0]          ram_addr;
  logic [lsfe_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

  assign in_ch.ready = in_ready;

  lsfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lsfe_dp #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .cmd       (cmd),
    .status    (status),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  lsfe_ram #(
    .WIDTH (lsfe_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire
